// File: sv/scv_pkg.sv
// ----------------------------------------------------------------------------
// scv_pkg: shared types and constants for the two-voice stereo chorus
// Widths, register codes, clamp limits, control structs and the 24-bit
// saturation used by the voice and mixer datapaths.
// ----------------------------------------------------------------------------
package scv_pkg;

  // delay store geometry
  localparam int unsigned DelayDepth = 1024;
  localparam int unsigned AddrW      = $clog2(DelayDepth);
  localparam int unsigned CntW       = AddrW + 1;

  // field widths
  localparam int unsigned SampleW  = 24;
  localparam int unsigned VoiceW   = 25;
  localparam int unsigned PhaseW   = 24;
  localparam int unsigned BaseW    = 17;
  localparam int unsigned StepW    = 21;
  localparam int unsigned DepthW   = 16;
  localparam int unsigned GainW    = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 21;

  // shared multiplier in each voice
  localparam int unsigned MulAW = 26;
  localparam int unsigned MulBW = 18;
  localparam int unsigned MulPW = 44;

  // depth * base product is split in a low and a high part
  localparam int unsigned QW    = DepthW + BaseW;
  localparam int unsigned QLoW  = 17;
  localparam int unsigned QHiW  = QW - QLoW;

  // offset accumulator and total delay (signed, Q.8 samples)
  localparam int unsigned AccW     = 57;
  localparam int unsigned AccShift = 38;
  localparam int unsigned OfsW     = AccW - AccShift;
  localparam int unsigned DlyW     = 22;
  localparam int unsigned FracW    = 8;

  localparam int unsigned FbShift  = 16;
  localparam int unsigned MixW     = 44;
  localparam int unsigned MixShift = 18;
  localparam int unsigned SatInW   = 26;

  localparam int OneQ22 = 4194304;

  // clamp limits
  localparam logic [StepW-1:0]  StepMax  = StepW'(1048576);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(60948);
  localparam logic [GainW-1:0]  UnitQ16  = GainW'(65536);

  // reset values
  localparam logic [BaseW-1:0]  DelayRst = BaseW'(74035);
  localparam logic [StepW-1:0]  StepRst  = StepW'(105);
  localparam logic [DepthW-1:0] DepthRst = DepthW'(58982);
  localparam logic [GainW-1:0]  FbRst    = GainW'(13107);
  localparam logic [GainW-1:0]  PanARst  = GainW'(16384);
  localparam logic [GainW-1:0]  PanBRst  = GainW'(49152);

  localparam logic signed [SatInW-1:0] SatHi = SatInW'(8388607);
  localparam logic signed [SatInW-1:0] SatLo = SatInW'(-8388608);

  typedef enum logic [CfgIdxW-1:0] {
    REG_DELAY_A  = 3'd0,
    REG_DELAY_B  = 3'd1,
    REG_STEP_A   = 3'd2,
    REG_STEP_B   = 3'd3,
    REG_DEPTH    = 3'd4,
    REG_FEEDBACK = 3'd5,
    REG_PAN_A    = 3'd6,
    REG_PAN_B    = 3'd7
  } cfg_reg_e;

  // per-voice settings, already clamped
  typedef struct packed {
    logic [BaseW-1:0]  base;
    logic [StepW-1:0]  step;
    logic [DepthW-1:0] depth;
    logic [GainW-1:0]  fb;
  } vcfg_t;

  // one strobe per voice step; at most one is high
  typedef struct packed {
    logic lfo;
    logic ofs0;
    logic ofs1;
    logic ofs2;
    logic dly;
    logic rd;
    logic itp;
    logic sum;
    logic fbm;
    logic wr;
  } vctl_t;

  typedef struct packed {
    logic mx0;
    logic mx1;
  } mctl_t;

  function automatic logic signed [SampleW-1:0] sat_s24(input logic signed [SatInW-1:0] x);
    logic signed [SatInW-1:0] y;
    y = x;
    if (x > SatHi) y = SatHi;
    if (x < SatLo) y = SatLo;
    return y[SampleW-1:0];
  endfunction

endpackage

// File: sv/scv_voice.sv
// ----------------------------------------------------------------------------
// scv_voice: one chorus voice
// Triangle LFO, delay store with two read ports, interpolation and feedback
// write-back, all through one shared registered multiplier.
// ----------------------------------------------------------------------------
module scv_voice (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  scv_pkg::vcfg_t                       cfg_i,
  input  scv_pkg::vctl_t                       ctl_i,
  input  logic signed [scv_pkg::SampleW-1:0]   sample_i,
  input  logic        [scv_pkg::AddrW-1:0]     wr_idx_i,
  input  logic        [scv_pkg::CntW-1:0]      fill_i,
  output logic signed [scv_pkg::VoiceW-1:0]    voice_o
);
  import scv_pkg::*;

  localparam logic signed [PhaseW:0]   OneQ     = (PhaseW+1)'(OneQ22);
  localparam logic signed [PhaseW:0]   TwoQ     = (PhaseW+1)'(2 * OneQ22);
  localparam logic signed [AccW-1:0]   AccRound = {{(AccW-AccShift){1'b0}}, 1'b1,
                                                   {(AccShift-1){1'b0}}};
  localparam logic signed [DlyW-1:0]   DMin     = DlyW'(256);
  localparam logic signed [DlyW-1:0]   DMax     = DlyW'((DelayDepth - 1) * 256);
  localparam logic signed [MulPW-1:0]  ItpRound = MulPW'(128);
  localparam logic signed [MulPW-1:0]  FbRound  = MulPW'(32768);
  localparam logic        [AddrW:0]    DepthC   = (AddrW+1)'(DelayDepth);

  // LFO state
  logic signed [PhaseW-1:0] phase_q, phase_d;
  logic                     falling_q, falling_d;
  logic signed [PhaseW:0]   step_s, p_sum, refl_hi, refl_lo;

  // datapath registers
  logic signed [MulPW-1:0]      prod_q;
  logic        [QHiW-1:0]       qh_q;
  logic signed [AccW-1:0]       acc_q;
  logic        [AddrW+FracW-1:0] d_q;
  logic                         ok_a_q, ok_b_q;
  logic        [SampleW-1:0]    rd_a_q, rd_b_q;
  logic signed [SampleW-1:0]    a_q;
  logic signed [SampleW-1:0]    rd_q;
  logic signed [VoiceW-1:0]     voice_q;

  logic [SampleW-1:0] mem [DelayDepth];

  // multiplier operands
  logic                    mul_en;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;

  logic signed [OfsW-1:0]    ofs;
  logic signed [DlyW-1:0]    d_sum;
  logic        [AddrW+FracW-1:0] d_clamp;
  logic        [AddrW-1:0]   age;
  logic        [AddrW:0]     raw_a, raw_b;
  logic        [AddrW-1:0]   addr_a, addr_b;
  logic signed [SampleW-1:0] a_val, b_val;
  logic signed [VoiceW-1:0]  diff;
  logic signed [MulPW-1:0]   itp_t, fb_t;
  logic        [VoiceW-1:0]  rd_full;
  logic        [VoiceW-1:0]  fbv;
  logic signed [SatInW-1:0]  wsum;
  logic signed [SampleW-1:0] wval;

  // LFO advance with reflection at plus and minus one
  always_comb begin
    step_s    = $signed({{(PhaseW+1-StepW){1'b0}}, cfg_i.step});
    p_sum     = {phase_q[PhaseW-1], phase_q} + (falling_q ? -step_s : step_s);
    refl_hi   = TwoQ - p_sum;
    refl_lo   = -TwoQ - p_sum;
    phase_d   = phase_q;
    falling_d = falling_q;
    if (ctl_i.lfo) begin
      priority if (p_sum > OneQ) begin
        phase_d   = refl_hi[PhaseW-1:0];
        falling_d = ~falling_q;
      end else if (p_sum < -OneQ) begin
        phase_d   = refl_lo[PhaseW-1:0];
        falling_d = ~falling_q;
      end else begin
        phase_d   = p_sum[PhaseW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      falling_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      falling_q <= falling_d;
    end
  end

  // read side: ages i and i+1 behind the write pointer
  always_comb begin
    a_val = ok_a_q ? $signed(rd_a_q) : '0;
    b_val = ok_b_q ? $signed(rd_b_q) : '0;
    diff  = {b_val[SampleW-1], b_val} - {a_val[SampleW-1], a_val};

    age   = d_q[AddrW+FracW-1:FracW];
    raw_a = {1'b0, wr_idx_i} - {1'b0, age};
    raw_b = raw_a - (AddrW+1)'(1);
    addr_a = raw_a[AddrW] ? AddrW'(raw_a + DepthC) : raw_a[AddrW-1:0];
    addr_b = raw_b[AddrW] ? AddrW'(raw_b + DepthC) : raw_b[AddrW-1:0];
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = ctl_i.lfo | ctl_i.ofs0 | ctl_i.ofs1 | ctl_i.itp | ctl_i.fbm;
    mul_a  = '0;
    mul_b  = '0;
    priority if (ctl_i.lfo) begin
      mul_a = $signed({{(MulAW-DepthW){1'b0}}, cfg_i.depth});
      mul_b = $signed({{(MulBW-BaseW){1'b0}}, cfg_i.base});
    end else if (ctl_i.ofs0) begin
      mul_a = {{(MulAW-PhaseW){phase_q[PhaseW-1]}}, phase_q};
      mul_b = $signed({{(MulBW-QLoW){1'b0}}, prod_q[QLoW-1:0]});
    end else if (ctl_i.ofs1) begin
      mul_a = {{(MulAW-PhaseW){phase_q[PhaseW-1]}}, phase_q};
      mul_b = $signed({{(MulBW-QHiW){1'b0}}, qh_q});
    end else if (ctl_i.itp) begin
      mul_a = {{(MulAW-VoiceW){diff[VoiceW-1]}}, diff};
      mul_b = $signed({{(MulBW-FracW){1'b0}}, d_q[FracW-1:0]});
    end else if (ctl_i.fbm) begin
      mul_a = {{(MulAW-SampleW){rd_q[SampleW-1]}}, rd_q};
      mul_b = $signed({{(MulBW-GainW){1'b0}}, cfg_i.fb});
    end
  end

  // total delay, clamped to the usable part of the store
  always_comb begin
    ofs   = acc_q[AccW-1:AccShift];
    d_sum = $signed({{(DlyW-BaseW){1'b0}}, cfg_i.base}) + {{(DlyW-OfsW){ofs[OfsW-1]}}, ofs};
    priority if (d_sum < DMin) begin
      d_clamp = DMin[AddrW+FracW-1:0];
    end else if (d_sum > DMax) begin
      d_clamp = DMax[AddrW+FracW-1:0];
    end else begin
      d_clamp = d_sum[AddrW+FracW-1:0];
    end
  end

  always_comb begin
    itp_t   = prod_q + ItpRound;
    rd_full = {a_q[SampleW-1], a_q} + itp_t[VoiceW+FracW-1:FracW];
    fb_t    = prod_q + FbRound;
    fbv     = fb_t[VoiceW+FbShift-1:FbShift];
    wsum    = {{(SatInW-SampleW){sample_i[SampleW-1]}}, sample_i}
            + {{(SatInW-VoiceW){fbv[VoiceW-1]}}, fbv};
    wval    = sat_s24(wsum);
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= MulPW'(mul_a) * MulPW'(mul_b);
    if (ctl_i.ofs0) qh_q <= prod_q[QW-1:QLoW];
    if (ctl_i.ofs1) acc_q <= {{(AccW-MulPW){prod_q[MulPW-1]}}, prod_q} + AccRound;
    if (ctl_i.ofs2) acc_q <= acc_q + ({{(AccW-MulPW){prod_q[MulPW-1]}}, prod_q} <<< QLoW);
    if (ctl_i.dly) d_q <= d_clamp;
    if (ctl_i.rd) begin
      // an entry older than the fill count was never written and reads as zero
      ok_a_q <= CntW'(age) <= fill_i;
      ok_b_q <= CntW'(age) < fill_i;
    end
    if (ctl_i.itp) a_q <= a_val;
    if (ctl_i.sum) rd_q <= rd_full[SampleW-1:0];
    if (ctl_i.wr) voice_q <= {sample_i[SampleW-1], sample_i} + {rd_q[SampleW-1], rd_q};
  end

  // delay store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) mem[wr_idx_i] <= wval;
    if (ctl_i.rd) begin
      rd_a_q <= mem[addr_a];
      rd_b_q <= mem[addr_b];
    end
  end

  assign voice_o = voice_q;

endmodule

// File: sv/scv_mixer.sv
// ----------------------------------------------------------------------------
// scv_mixer: stereo pan of the two voices
// Two multipliers (left, right) take voice A then voice B; the sum is
// rounded, divided by four and saturated to the output width.
// ----------------------------------------------------------------------------
module scv_mixer (
  input  logic                               clk_i,
  input  scv_pkg::mctl_t                     ctl_i,
  input  logic signed [scv_pkg::VoiceW-1:0]  voice_a_i,
  input  logic signed [scv_pkg::VoiceW-1:0]  voice_b_i,
  input  logic        [scv_pkg::GainW-1:0]   pan_a_i,
  input  logic        [scv_pkg::GainW-1:0]   pan_b_i,
  output logic signed [scv_pkg::SampleW-1:0] left_o,
  output logic signed [scv_pkg::SampleW-1:0] right_o
);
  import scv_pkg::*;

  localparam logic signed [MixW-1:0] MixRound = MixW'(131072);

  logic signed [GainW:0]   gl, gr;
  logic signed [VoiceW-1:0] v_sel;
  logic        [GainW-1:0] pan_sel;
  logic signed [MixW-1:0]  pl_q, pr_q, al_q, ar_q;
  logic signed [MixW-1:0]  sl, sr;

  always_comb begin
    pan_sel = ctl_i.mx0 ? pan_a_i : pan_b_i;
    v_sel   = ctl_i.mx0 ? voice_a_i : voice_b_i;
    gr      = $signed({1'b0, pan_sel});
    gl      = $signed({1'b0, UnitQ16 - pan_sel});
    sl      = al_q + pl_q;
    sr      = ar_q + pr_q;
    left_o  = sat_s24(sl[MixShift+SatInW-1:MixShift]);
    right_o = sat_s24(sr[MixShift+SatInW-1:MixShift]);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mx0 | ctl_i.mx1) begin
      pl_q <= MixW'(gl) * MixW'(v_sel);
      pr_q <= MixW'(gr) * MixW'(v_sel);
    end
    if (ctl_i.mx1) begin
      al_q <= pl_q + MixRound;
      ar_q <= pr_q + MixRound;
    end
  end

endmodule

// File: sv/stereo_chorus_two_voice_core.sv
// ----------------------------------------------------------------------------
// stereo_chorus_two_voice_core: two-voice stereo chorus
// One signed sample in, one left/right pair out. Two LFO-modulated delay
// voices with feedback, panned and summed.
//
//   channel   direction  handshake               payload
//   cfg       in         cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//   in        in         in_valid_i/in_ready_o   sample_in_i
//   out       out        out_valid_o/out_ready_i left_out_o, right_out_o
//
// Each sample passes through five products per voice on its shared
// multiplier, the store read and two mixer product steps before the next
// accept. Both voices run in lockstep.
// After reset the stores read as zero through a fill count; there is no
// clearing pass and a sample can be accepted as soon as reset is released.
// A finished pair waits in the output register; the next sample is taken
// meanwhile and only stalls at its last step while out is still full.
// ----------------------------------------------------------------------------
module stereo_chorus_two_voice_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [scv_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic        [scv_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [scv_pkg::SampleW-1:0]   sample_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [scv_pkg::SampleW-1:0]   left_out_o,
  output logic signed [scv_pkg::SampleW-1:0]   right_out_o
);
  import scv_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_OFS0 = 13'b0000000000010,
    ST_OFS1 = 13'b0000000000100,
    ST_OFS2 = 13'b0000000001000,
    ST_DLY  = 13'b0000000010000,
    ST_RD   = 13'b0000000100000,
    ST_ITP  = 13'b0000001000000,
    ST_SUM  = 13'b0000010000000,
    ST_FBM  = 13'b0000100000000,
    ST_WR   = 13'b0001000000000,
    ST_MX0  = 13'b0010000000000,
    ST_MX1  = 13'b0100000000000,
    ST_MX2  = 13'b1000000000000
  } fsm_state_e;

  fsm_state_e state_q, state_d;

  // configuration registers
  logic [BaseW-1:0]  delay_a_q, delay_b_q;
  logic [StepW-1:0]  step_a_q, step_b_q;
  logic [DepthW-1:0] depth_q;
  logic [GainW-1:0]  fb_q, pan_a_q, pan_b_q;

  logic [StepW-1:0]  step_a_c, step_b_c;
  logic [DepthW-1:0] depth_c;
  logic [GainW-1:0]  fb_c, pan_a_c, pan_b_c;

  logic signed [SampleW-1:0] x_q;
  logic        [AddrW-1:0]   wr_idx_q;
  logic        [CntW-1:0]    fill_q;
  logic                      out_valid_q;
  logic signed [SampleW-1:0] left_q, right_q;

  logic                      in_fire, out_load;
  vcfg_t                     vcfg_a, vcfg_b;
  vctl_t                     vctl;
  mctl_t                     mctl;
  logic signed [VoiceW-1:0]  voice_a, voice_b;
  logic signed [SampleW-1:0] mix_left, mix_right;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_a_q <= DelayRst;
      delay_b_q <= DelayRst;
      step_a_q  <= StepRst;
      step_b_q  <= StepRst;
      depth_q   <= DepthRst;
      fb_q      <= FbRst;
      pan_a_q   <= PanARst;
      pan_b_q   <= PanBRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DELAY_A:  delay_a_q <= cfg_data_i[BaseW-1:0];
        REG_DELAY_B:  delay_b_q <= cfg_data_i[BaseW-1:0];
        REG_STEP_A:   step_a_q  <= cfg_data_i[StepW-1:0];
        REG_STEP_B:   step_b_q  <= cfg_data_i[StepW-1:0];
        REG_DEPTH:    depth_q   <= cfg_data_i[DepthW-1:0];
        REG_FEEDBACK: fb_q      <= cfg_data_i[GainW-1:0];
        REG_PAN_A:    pan_a_q   <= cfg_data_i[GainW-1:0];
        REG_PAN_B:    pan_b_q   <= cfg_data_i[GainW-1:0];
      endcase
    end
  end

  always_comb begin
    step_a_c = (step_a_q > StepMax)  ? StepMax  : step_a_q;
    step_b_c = (step_b_q > StepMax)  ? StepMax  : step_b_q;
    depth_c  = (depth_q  > DepthMax) ? DepthMax : depth_q;
    fb_c     = (fb_q     > UnitQ16)  ? UnitQ16  : fb_q;
    pan_a_c  = (pan_a_q  > UnitQ16)  ? UnitQ16  : pan_a_q;
    pan_b_c  = (pan_b_q  > UnitQ16)  ? UnitQ16  : pan_b_q;

    vcfg_a = '{base: delay_a_q, step: step_a_c, depth: depth_c, fb: fb_c};
    vcfg_b = '{base: delay_b_q, step: step_b_c, depth: depth_c, fb: fb_c};
  end

  // sequencer
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_load   = (state_q == ST_MX2) & (~out_valid_q | out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_OFS0;
      ST_OFS0: state_d = ST_OFS1;
      ST_OFS1: state_d = ST_OFS2;
      ST_OFS2: state_d = ST_DLY;
      ST_DLY:  state_d = ST_RD;
      ST_RD:   state_d = ST_ITP;
      ST_ITP:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_FBM;
      ST_FBM:  state_d = ST_WR;
      ST_WR:   state_d = ST_MX0;
      ST_MX0:  state_d = ST_MX1;
      ST_MX1:  state_d = ST_MX2;
      ST_MX2:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    vctl = '{lfo:  in_fire,
             ofs0: state_q == ST_OFS0,
             ofs1: state_q == ST_OFS1,
             ofs2: state_q == ST_OFS2,
             dly:  state_q == ST_DLY,
             rd:   state_q == ST_RD,
             itp:  state_q == ST_ITP,
             sum:  state_q == ST_SUM,
             fbm:  state_q == ST_FBM,
             wr:   state_q == ST_WR};
    mctl = '{mx0: state_q == ST_MX0, mx1: state_q == ST_MX1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_idx_q    <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (vctl.wr) begin
        wr_idx_q <= (wr_idx_q == AddrW'(DelayDepth - 1)) ? '0 : wr_idx_q + AddrW'(1);
        if (fill_q != CntW'(DelayDepth)) fill_q <= fill_q + CntW'(1);
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) x_q <= sample_in_i;
    if (out_load) begin
      left_q  <= mix_left;
      right_q <= mix_right;
    end
  end

  scv_voice u_voice_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (vcfg_a),
    .ctl_i    (vctl),
    .sample_i (x_q),
    .wr_idx_i (wr_idx_q),
    .fill_i   (fill_q),
    .voice_o  (voice_a)
  );

  scv_voice u_voice_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (vcfg_b),
    .ctl_i    (vctl),
    .sample_i (x_q),
    .wr_idx_i (wr_idx_q),
    .fill_i   (fill_q),
    .voice_o  (voice_b)
  );

  scv_mixer u_mixer (
    .clk_i     (clk_i),
    .ctl_i     (mctl),
    .voice_a_i (voice_a),
    .voice_b_i (voice_b),
    .pan_a_i   (pan_a_c),
    .pan_b_i   (pan_b_c),
    .left_o    (mix_left),
    .right_o   (mix_right)
  );

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;

endmodule

// File: sv/scv_checker.sv
// ----------------------------------------------------------------------------
// scv_checker: port-level checks for the stereo chorus core
// Sequencing of the input side against the output register, bound to the
// top level.
// ----------------------------------------------------------------------------
module scv_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [scv_pkg::SampleW-1:0] left_out_o,
  input logic signed [scv_pkg::SampleW-1:0] right_out_o
);

  // one sample in flight: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready still high after accept");

  // ready is still low when a sample reaches its last step
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> ##12 !in_ready_o)
    else $error("sample finished too early");

  // returning to ready means a result word was just loaded
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o)
    else $error("ready returned without a result word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(left_out_o) && $stable(right_out_o)))
    else $error("stalled result word changed");

endmodule

bind stereo_chorus_two_voice_core scv_checker u_scv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .left_out_o  (left_out_o),
  .right_out_o (right_out_o)
);

// File: bench/stereo_chorus_two_voice_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_chorus_two_voice_core_tb: self-checking bench for the stereo chorus
// Drives samples and register settings, and keeps its own model of both
// voices (triangle LFOs, delay stores, feedback) and the pan mixer. Every
// output word is compared against the predicted left/right pair, under
// several idle and stall mixes on both channels.
// ----------------------------------------------------------------------------
module stereo_chorus_two_voice_core_tb;
  import scv_pkg::*;

  localparam int     CycleLimit = 1000000;
  localparam int     ItemsPerSet = 190;
  localparam int     NumSets     = 8;
  localparam longint WordMax     = 8388607;
  localparam longint WordMin     = -8388608;

  typedef struct packed {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
  } pair_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]          cfg_idx_i = REG_DELAY_A;
  logic [CfgDataW-1:0]         cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic signed [SampleW-1:0]   sample_in_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [SampleW-1:0]   left_out_o;
  logic signed [SampleW-1:0]   right_out_o;

  stereo_chorus_two_voice_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // model state
  logic [CfgDataW-1:0]       reg_val [8];
  logic signed [SampleW-1:0] echo_mem [2][DelayDepth];
  logic signed [PhaseW-1:0]  lfo_phase [2];
  logic                      lfo_down [2];
  int unsigned               wr_ptr;

  pair_t expected_pairs [$];
  pair_t want;
  int    mismatches = 0;
  int    cycle_count = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  function automatic longint clamp_to(input longint v, input longint lim);
    return (v > lim) ? lim : v;
  endfunction

  // round half up, i.e. floor of (x + half) >> s
  function automatic longint rnd_shift(input longint x, input int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [SampleW-1:0] sat_word(input longint x);
    longint y;
    y = x;
    if (y > WordMax) y = WordMax;
    if (y < WordMin) y = WordMin;
    return y[SampleW-1:0];
  endfunction

  function automatic logic [CfgDataW-1:0] reg_mask(input cfg_reg_e r);
    unique case (r)
      REG_STEP_A, REG_STEP_B: return 21'h1FFFFF;
      REG_DEPTH:              return 21'h00FFFF;
      default:                return 21'h01FFFF;
    endcase
  endfunction

  function automatic int age_slot(input longint age);
    return int'((longint'(wr_ptr) + 2 * longint'(DelayDepth) - age) % longint'(DelayDepth));
  endfunction

  // one voice step; returns input + tap (twice the voice signal)
  function automatic longint voice_tap(input int v, input longint x);
    longint base, step, depth, fb, p, d, whole, frac, a, b, rd, w;
    base  = v ? reg_val[REG_DELAY_B] : reg_val[REG_DELAY_A];
    step  = clamp_to(v ? reg_val[REG_STEP_B] : reg_val[REG_STEP_A], longint'(StepMax));
    depth = clamp_to(reg_val[REG_DEPTH], longint'(DepthMax));
    fb    = clamp_to(reg_val[REG_FEEDBACK], longint'(UnitQ16));
    p = longint'(lfo_phase[v]) + (lfo_down[v] ? -step : step);
    if (p > OneQ22) begin
      p = 2 * OneQ22 - p;
      lfo_down[v] = ~lfo_down[v];
    end else if (p < -OneQ22) begin
      p = -2 * OneQ22 - p;
      lfo_down[v] = ~lfo_down[v];
    end
    lfo_phase[v] = p[PhaseW-1:0];
    d = base + rnd_shift(p * depth * base, AccShift);
    if (d < 256) d = 256;
    if (d > longint'(DelayDepth - 1) * 256) d = longint'(DelayDepth - 1) * 256;
    whole = d >>> FracW;
    frac  = d & 255;
    a  = echo_mem[v][age_slot(whole)];
    b  = echo_mem[v][age_slot(whole + 1)];
    rd = a + rnd_shift((b - a) * frac, FracW);
    w  = sat_word(x + rnd_shift(rd * fb, FbShift));
    echo_mem[v][wr_ptr] = w[SampleW-1:0];
    return x + rd;
  endfunction

  function automatic pair_t predict_pair(input logic signed [SampleW-1:0] s);
    longint x, va, vb, pa, pb, unit;
    pair_t r;
    x  = s;
    va = voice_tap(0, x);
    vb = voice_tap(1, x);
    unit = UnitQ16;
    pa = clamp_to(reg_val[REG_PAN_A], unit);
    pb = clamp_to(reg_val[REG_PAN_B], unit);
    r.left  = sat_word(rnd_shift((unit - pa) * va + (unit - pb) * vb, MixShift));
    r.right = sat_word(rnd_shift(pa * va + pb * vb, MixShift));
    wr_ptr = (wr_ptr + 1) % DelayDepth;
    return r;
  endfunction

  task automatic write_reg(input cfg_reg_e r, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= data;
    reg_val[r] = data & reg_mask(r);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(input logic [CfgDataW-1:0] dly_a, input logic [CfgDataW-1:0] dly_b,
                           input logic [CfgDataW-1:0] stp_a, input logic [CfgDataW-1:0] stp_b,
                           input logic [CfgDataW-1:0] dep, input logic [CfgDataW-1:0] fbk,
                           input logic [CfgDataW-1:0] pn_a, input logic [CfgDataW-1:0] pn_b);
    write_reg(REG_DELAY_A, dly_a);
    write_reg(REG_DELAY_B, dly_b);
    write_reg(REG_STEP_A, stp_a);
    write_reg(REG_STEP_B, stp_b);
    write_reg(REG_DEPTH, dep);
    write_reg(REG_FEEDBACK, fbk);
    write_reg(REG_PAN_A, pn_a);
    write_reg(REG_PAN_B, pn_b);
  endtask

  // valid is left high after accept; the next call lowers it only for a gap
  task automatic send_sample(input logic signed [SampleW-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    expected_pairs.push_back(predict_pair(s));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_idling(input int mode);
    unique case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default: begin send_idle_pct = 26; recv_stall_pct = 26; end
    endcase
  endtask

  function automatic logic signed [SampleW-1:0] rand_sample();
    logic [SampleW-1:0] u;
    u = SampleW'($urandom());
    unique case ($urandom_range(9))
      0: return sat_word(WordMax - $urandom_range(0, 4000));
      1: return sat_word(WordMin + $urandom_range(0, 4000));
      2, 3: return sat_word(longint'($urandom_range(0, 8191)) - 4096);
      default: return u;
    endcase
  endfunction

  task automatic test_reset_settings();
    set_idling(3);
    send_sample(24'sh7FFFFF);
    send_sample(-24'sh800000);
    send_sample(24'sh000000);
    send_sample(-24'sh000001);
    send_sample(24'sh000001);
    send_sample(24'sh555555);
    send_sample(-24'sh555556);
    drain();
  endtask

  // over-range registers clamp, base below one sample clamps the delay,
  // full-size steps reflect the LFO within a few words
  task automatic test_clamps_and_reflection();
    set_idling(0);
    write_all(21'h000000, 21'h1FFFFF, 21'h1FFFFF, 21'd1048576,
              21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h000000);
    for (int k = 0; k < 6; k++) send_sample(k[0] ? 24'sh7FFFFF : -24'sh800000);
    drain();
    // rewrite the steps mid-sweep; direction bits must survive
    write_reg(REG_STEP_A, 21'd1000);
    write_reg(REG_STEP_B, 21'd1048577);
    write_reg(REG_DELAY_A, 21'd255);
    write_reg(REG_PAN_B, 21'd65536);
    for (int k = 0; k < 8; k++) send_sample(k[1] ? 24'sh7FFFF0 : -24'sh7FFFF0);
    drain();
  endtask

  task automatic test_random_settings();
    for (int set = 0; set < NumSets; set++) begin
      unique case (set)
        0: write_all(21'd256, 21'd256, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0);
        1: write_all(21'd131071, 21'd131071, 21'd1048576, 21'd1048576,
                     21'd60948, 21'd65536, 21'd65536, 21'd65536);
        2: write_all(21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF,
                     21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF);
        default: begin
          write_all(CfgDataW'($urandom_range(7) == 0 ? $urandom_range(0, 255)
                                                     : $urandom_range(256, 131071)),
                    CfgDataW'($urandom_range(7) == 0 ? $urandom()
                                                     : $urandom_range(256, 131071)),
                    CfgDataW'($urandom_range(1) ? $urandom_range(0, 4000) : $urandom()),
                    CfgDataW'($urandom_range(1) ? $urandom_range(0, 4000) : $urandom()),
                    CfgDataW'($urandom()), CfgDataW'($urandom()),
                    CfgDataW'($urandom()), CfgDataW'($urandom()));
        end
      endcase
      set_idling(set % 4);
      for (int k = 0; k < ItemsPerSet; k++) send_sample(rand_sample());
      drain();
    end
  endtask

  // output check and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pairs.size() == 0) begin
        $error("unexpected word: left_out %0d right_out %0d", left_out_o, right_out_o);
        mismatches++;
      end else begin
        want = expected_pairs.pop_front();
        if (left_out_o !== want.left) begin
          $error("left_out: expected %0d, got %0d", want.left, left_out_o);
          mismatches++;
        end
        if (right_out_o !== want.right) begin
          $error("right_out: expected %0d, got %0d", want.right, right_out_o);
          mismatches++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[stereo_chorus_two_voice_core] ERROR");
      $finish;
    end
  end

  initial begin
    reg_val[REG_DELAY_A]  = DelayRst;
    reg_val[REG_DELAY_B]  = DelayRst;
    reg_val[REG_STEP_A]   = StepRst;
    reg_val[REG_STEP_B]   = StepRst;
    reg_val[REG_DEPTH]    = DepthRst;
    reg_val[REG_FEEDBACK] = FbRst;
    reg_val[REG_PAN_A]    = PanARst;
    reg_val[REG_PAN_B]    = PanBRst;
    for (int v = 0; v < 2; v++) begin
      for (int k = 0; k < DelayDepth; k++) echo_mem[v][k] = '0;
      lfo_phase[v] = '0;
      lfo_down[v]  = 1'b0;
    end
    wr_ptr = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_settings();
    test_clamps_and_reflection();
    test_random_settings();

    if (mismatches == 0) begin
      $display("[stereo_chorus_two_voice_core] OK");
    end else begin
      $display("[stereo_chorus_two_voice_core] ERROR");
    end
    $finish;
  end

endmodule
